[design/fqd_pkg.sv]
// Shared operation codes, item width and control struct for the queue with delete.
`default_nettype none
package fqd_pkg;

  // Operation codes on the op field
  localparam logic [1:0] OP_ENQUEUE = 2'd0;
  localparam logic [1:0] OP_DEQUEUE = 2'd1;
  localparam logic [1:0] OP_DELETE  = 2'd2;
  localparam logic [1:0] OP_LENGTH  = 2'd3;

  // Width of the item and item_out fields on the ports
  localparam int ITEM_W = 32;

  // Per-word control broadcast to every cell of the chain
  typedef struct packed {
    logic enq;   // enqueue goes ahead this cycle
    logic deq;   // dequeue goes ahead this cycle
    logic del;   // delete word accepted with a non-null handle
  } cell_ctrl_t;

endpackage
`default_nettype wire

[design/fifo_queue_with_delete.sv]
// Top level: bounded FIFO of nonzero handles with delete by value, built as a cell chain.
// Usage:
//   in_valid/in_ready carry one operation word (in_op, in_item); out_valid/out_ready
//   carry one result word (out_status, out_item_out, out_count) for every operation.
//   Enqueue appends at the tail, dequeue returns the head, delete removes the first
//   entry from the head equal to in_item, length just reports the count. A null
//   handle on enqueue or delete, full, empty or no match gives out_status 1 and leaves the queue as is.
// Timing and throughput:
//   One word per cycle unless a result waits; the result is in the output register
//   in the cycle after acceptance. Every operation, delete included, completes on
//   acceptance, as cells compare in parallel and a found flag ripples along the chain.
// Stalls:
//   in_ready stays high while the output register is empty or being taken, so a new
//   word is accepted in the same cycle a result leaves. If out_ready is low and a
//   result waits, in_ready drops until the result is taken.
// Reset:
//   rst_n (synchronous, active low) empties the queue and the output register; the
//   stored handles themselves are not cleared and no clearing pass is needed.
`default_nettype none
module fifo_queue_with_delete import fqd_pkg::*; #(
  parameter int DEPTH       = 16,
  parameter int HANDLE_BITS = 32,
  localparam int CW         = $clog2(DEPTH + 1)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [1:0]        in_op,
  input  wire logic [ITEM_W-1:0] in_item,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   out_status,
  output logic [ITEM_W-1:0]      out_item_out,
  output logic [CW-1:0]          out_count
);

  // Handle bits actually held: the port carries at most ITEM_W of them
  localparam int HW = (HANDLE_BITS < ITEM_W) ? HANDLE_BITS : ITEM_W;

  logic                  accept;
  logic [HW-1:0]         handle;
  logic                  handle_nz;
  logic [CW-1:0]         occ_r, occ_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_status_r;
  logic [ITEM_W-1:0]     out_item_r;
  logic [CW-1:0]         out_count_r;
  logic                  enq_ok, deq_ok, del_ok, ok;
  cell_ctrl_t            ctrl;
  logic [DEPTH-1:0][HW-1:0] cell_data;
  logic [DEPTH:0]        found;

  // Handshake: the output register frees up as its word leaves
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  assign handle    = in_item[HW-1:0];
  assign handle_nz = (handle != '0);

  // Operation decode
  assign enq_ok = (in_op == OP_ENQUEUE) && handle_nz && (occ_r != CW'(DEPTH));
  assign deq_ok = (in_op == OP_DEQUEUE) && (occ_r != '0);
  assign del_ok = (in_op == OP_DELETE) && handle_nz && found[DEPTH];

  always_comb begin
    ctrl.enq = accept && enq_ok;
    ctrl.deq = accept && deq_ok;
    ctrl.del = accept && (in_op == OP_DELETE) && handle_nz;
  end

  // Chain of cells
  assign found[0] = 1'b0;
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [HW-1:0] nbr;
    if (i == DEPTH - 1) begin : g_last
      assign nbr = cell_data[i];
    end else begin : g_mid
      assign nbr = cell_data[i+1];
    end
    fqd_cell #(.HW(HW)) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .handle    (handle),
      .held      (occ_r > CW'(i)),
      .at_tail   (occ_r == CW'(i)),
      .nbr_data  (nbr),
      .found_in  (found[i]),
      .found_out (found[i+1]),
      .data      (cell_data[i])
    );
  end

  // Occupancy update
  always_comb begin
    occ_nxt = occ_r;
    if (accept) begin
      if (enq_ok) begin
        occ_nxt = occ_r + CW'(1);
      end else if (deq_ok || del_ok) begin
        occ_nxt = occ_r - CW'(1);
      end
    end
  end

  assign ok = enq_ok || deq_ok || del_ok || (in_op == OP_LENGTH);

  // Output register valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      out_status_r <= !ok;
      out_item_r   <= deq_ok ? ITEM_W'(cell_data[0]) : '0;
      out_count_r  <= occ_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_item_out = out_item_r;
  assign out_count    = out_count_r;

  // Checks
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CW'(DEPTH))
    else $error("occupancy above depth");

  a_deq_count: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (deq_ok || del_ok)) |=> (occ_r == $past(occ_r) - CW'(1)))
    else $error("removal did not lower occupancy");

  a_err_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !ok) |=> (occ_r == $past(occ_r) && out_status_r))
    else $error("error word changed occupancy");

  a_item_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r != '0) |-> (!out_status_r && out_count_r < CW'(DEPTH)))
    else $error("handle returned on a non-dequeue word");

endmodule
`default_nettype wire

[design/fqd_cell.sv]
// One queue position: holds a handle, compares it, and shifts from its neighbour.
`default_nettype none
module fqd_cell import fqd_pkg::*; #(
  parameter int HW = 32
) (
  input  wire logic          clk,
  input  wire cell_ctrl_t    ctrl,
  input  wire logic [HW-1:0] handle,
  input  wire logic          held,      // position lies below the occupancy
  input  wire logic          at_tail,   // position equals the occupancy
  input  wire logic [HW-1:0] nbr_data,  // data of the cell behind this one
  input  wire logic          found_in,  // a match exists ahead of this cell
  output logic               found_out,
  output logic [HW-1:0]      data
);

  logic [HW-1:0] data_r;
  logic [HW-1:0] data_nxt;
  logic          match;

  // Parallel compare, first-match ripple down the chain
  assign match     = ctrl.del && held && (data_r == handle);
  assign found_out = found_in || match;

  // Load at the tail, or close up behind a removed entry
  always_comb begin
    data_nxt = data_r;
    if (ctrl.enq && at_tail) begin
      data_nxt = handle;
    end else if (ctrl.deq || (ctrl.del && found_out)) begin
      data_nxt = nbr_data;
    end
  end

  // Payload only, no reset
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule
`default_nettype wire
